FILE: hdl/indexed_list_insert_remove_assert.svh
// Assertion macros shared by the indexed list RTL.
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ILIR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed list check failed");

// Next-cycle implication, disabled during reset
`define ILIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed list check failed");

`endif

FILE: hdl/ilir_pkg.sv
// Types, codes and sizes for the indexed list.
package ilir_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CAP_W      = 7;
   localparam int OPC_W      = 3;
   localparam int POS_W      = 6;
   localparam int STAT_W     = 2;
   localparam int COUNT_W    = 7;
   localparam int NUM_GROUPS = 8;
   localparam int GROUP_LEN  = DEPTH / NUM_GROUPS;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [CNT_W-1:0]             cnt_type;

   typedef enum logic [OPC_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_APPEND  = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_READ    = 3'd3,
      OP_REPLACE = 3'd4,
      OP_COMPARE = 3'd5,
      OP_CLEAR   = 3'd6
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADIDX = 2'd2
   } status_type;

   // Command broadcast along the row of cells
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_WRITE  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type kind;
      idx_type     position;
      data_type    value;
   } cell_cmd_type;

endpackage

FILE: hdl/ilir_interfaces.sv
// Valid/ready channel interfaces of the indexed list.
interface ilir_req_if import ilir_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OPC_W-1:0]        opcode;
   logic [POS_W-1:0]        position;
   logic signed [31:0]      value;

   modport source (output valid, opcode, position, value, input ready);
   modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface ilir_rsp_if import ilir_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [31:0]      read_value;
   logic                    match;
   logic [STAT_W-1:0]       status;
   logic [COUNT_W-1:0]      count;
   logic                    is_empty;
   logic                    is_full;

   modport source (output valid, read_value, match, status, count, is_empty, is_full,
                   input ready);
   modport sink   (input valid, read_value, match, status, count, is_empty, is_full,
                   output ready);
endinterface

interface ilir_csr_if import ilir_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CAP_W-1:0]        capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

FILE: hdl/ilir_cell.sv
// One entry cell of the list: holds an entry and trades it with its neighbours.
module ilir_cell import ilir_pkg::*; (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  idx_type      cell_index,
   input  data_type     below_data,
   input  data_type     above_data,
   output data_type     entry_data,
   output data_type     sel_data
);

   data_type entry_ff;
   data_type entry_in;
   logic     at_pos;
   logic     past_pos;

   assign at_pos   = (cell_index == cmd.position);
   assign past_pos = (cell_index > cmd.position);

   // Next entry: shift up, shift down, overwrite or hold
   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         CELL_INSERT: begin
            if (at_pos) begin
               entry_in = cmd.value;
            end else if (past_pos) begin
               entry_in = below_data;
            end
         end
         CELL_REMOVE: begin
            if (at_pos || past_pos) begin
               entry_in = above_data;
            end
         end
         CELL_WRITE: begin
            if (at_pos) begin
               entry_in = cmd.value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_data = entry_ff;
   // Only the addressed cell drives the gather tree
   assign sel_data   = at_pos ? entry_ff : '0;

endmodule

FILE: hdl/indexed_list_insert_remove.sv
// Top level of the indexed list: control, capacity register, gather tree, cell row.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------------
//  req_chan  | in  | valid / ready | opcode, position, value
//  rsp_chan  | out | valid / ready | read_value, match, status, count, flags
//  csr_chan  | in  | valid / ready | capacity (always ready)
//
//  Each item passes through accept, cell select, gather of the addressed entry
//  through a registered OR tree (8 groups of 8), then commit to the cell row.
//  Commit waits while the result register still holds an untaken result;
//  the next item is taken as soon as commit is done.
//  Reset clears the count, the control state and sets capacity to 64;
//  entries are left as they are.
`include "indexed_list_insert_remove_assert.svh"

module indexed_list_insert_remove import ilir_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ilir_req_if.sink    req_chan,
   ilir_rsp_if.source  rsp_chan,
   ilir_csr_if.sink    csr_chan
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOOK = 4'b0010,
      S_SUM  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   cnt_type             count_ff, count_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   opcode_type          op_ff;
   logic [POS_W-1:0]    pos_ff;
   data_type            val_ff;
   data_type            group_ff [NUM_GROUPS];
   data_type            group_in [NUM_GROUPS];
   data_type            rd_ff, rd_in;

   logic                rsp_valid_ff, rsp_valid_in;
   data_type            rsp_data_ff, rsp_data_in;
   logic                rsp_match_ff, rsp_match_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_full_ff, rsp_full_in;

   cnt_type             eff_cap;
   cnt_type             pos_ext;
   logic                req_fire;
   logic                fire;
   logic                list_full;
   logic                in_range;
   logic                ins_ok;
   cell_cmd_type        cmd;
   cell_op_type         cmd_kind;
   data_type            entry_w [DEPTH];
   data_type            sel_w   [DEPTH];

   // Capacity register
   assign csr_chan.ready = 1'b1;
   assign cap_in  = (csr_chan.valid) ? csr_chan.capacity : cap_ff;
   assign eff_cap = (cap_ff > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_ff);

   // Handshakes
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign fire           = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Index checks against the live count
   assign pos_ext   = CNT_W'(pos_ff);
   assign list_full = (count_ff >= eff_cap);
   assign in_range  = (pos_ext < count_ff);
   assign ins_ok    = (pos_ext <= count_ff);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_LOOK;
         S_LOOK:  state_in = S_SUM;
         S_SUM:   state_in = S_DONE;
         S_DONE:  if (fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outcome of the operation at commit
   always_comb begin
      cmd_kind      = CELL_HOLD;
      count_in      = count_ff;
      rsp_data_in   = '0;
      rsp_match_in  = 1'b0;
      rsp_status_in = ST_OK;
      case (op_ff)
         OP_INSERT, OP_APPEND: begin
            if (list_full) begin
               rsp_status_in = ST_FULL;
            end else if ((op_ff == OP_INSERT) && !ins_ok) begin
               rsp_status_in = ST_BADIDX;
            end else begin
               cmd_kind = CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (!in_range) begin
               rsp_status_in = ST_BADIDX;
            end else begin
               cmd_kind = CELL_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (!in_range) rsp_status_in = ST_BADIDX;
            else           rsp_data_in   = rd_ff;
         end
         OP_REPLACE: begin
            if (!in_range) rsp_status_in = ST_BADIDX;
            else           cmd_kind      = CELL_WRITE;
         end
         OP_COMPARE: begin
            if (!in_range) rsp_status_in = ST_BADIDX;
            else           rsp_match_in  = (rd_ff == val_ff);
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      if (!fire) begin
         cmd_kind = CELL_HOLD;
         count_in = count_ff;
      end
      rsp_full_in = (count_in >= eff_cap);
   end

   // Broadcast to the cells; append targets the slot just past the last entry
   assign cmd.kind     = cmd_kind;
   assign cmd.position = (op_ff == OP_APPEND) ? count_ff[IDX_W-1:0] : IDX_W'(pos_ff);
   assign cmd.value    = val_ff;

   // Row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      data_type below_w;
      data_type above_w;
      if (i == 0) begin : g_first
         assign below_w = '0;
      end else begin : g_mid_lo
         assign below_w = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign above_w = '0;
      end else begin : g_mid_hi
         assign above_w = entry_w[i+1];
      end
      ilir_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(i)),
         .below_data (below_w),
         .above_data (above_w),
         .entry_data (entry_w[i]),
         .sel_data   (sel_w[i])
      );
   end

   // Gather tree: first level per group, second level over groups
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_LEN; k++) begin
            group_in[g] = group_in[g] | sel_w[g*GROUP_LEN + k];
         end
      end
      rd_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         rd_in = rd_in | group_ff[g];
      end
   end

   // Result register holds until the sink takes it
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= opcode_type'(req_chan.opcode);
         pos_ff <= req_chan.position;
         val_ff <= req_chan.value;
      end
      group_ff <= group_in;
      rd_ff    <= rd_in;
      if (fire) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_match_ff  <= rsp_match_in;
         rsp_status_ff <= rsp_status_in;
         rsp_full_ff   <= rsp_full_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_data_ff;
   assign rsp_chan.match      = rsp_match_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.count      = COUNT_W'(count_ff);
   assign rsp_chan.is_empty   = (count_ff == '0);
   assign rsp_chan.is_full    = rsp_full_ff;

   // Checks
   `ILIR_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ILIR_ASSERT_NEXT(a_accept_to_look, clock, reset, req_fire, state_ff == S_LOOK)
   `ILIR_ASSERT_NEXT(a_commit_shows, clock, reset, fire, rsp_valid_ff)
   `ILIR_ASSERT_NEXT(a_count_on_commit, clock, reset, !fire, $stable(count_ff))

endmodule
